// File: sv/asa_pkg.sv
// Shared types and constants for the aligned stack allocator.
// No dependencies; imported by asa_ctrl, asa_dp and aligned_stack_allocator.
package asa_pkg;

    localparam int HDR_BYTES = 8;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_PUSH  = 2'd2,
        MODE_POP   = 2'd3
    } mode_t;

    typedef enum logic {
        REG_BASE     = 1'b0,
        REG_CAPACITY = 1'b1
    } reg_index_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture operands, issue marker read
        logic exec;   // evaluate operation, update state, register result
    } cmd_t;

endpackage

// File: sv/asa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module asa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/asa_ctrl.sv
// Sequencer for the allocator: idle / execute, busy and done strobe.
// Depends on asa_pkg.
module asa_ctrl
    import asa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        busy     = 1'b0;
        case (state_reg)
            ST_IDLE: cmd.load = start;
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                busy     = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.exec;
        end
    end

    assign done = done_reg;

endmodule

// File: sv/asa_dp.sv
// Datapath: region registers, top pointer, marker stack and result registers.
// Depends on asa_pkg and asa_ram.
module asa_dp
    import asa_pkg::*;
#(
    parameter int ALIGN        = 16,
    parameter int MARKER_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [1:0]  mode,
    input  logic [31:0] amount_or_pointer,
    input  logic [32:0] stored_header,
    output logic        ok,
    output logic [31:0] address,
    output logic [31:0] header_address,
    output logic [32:0] header_value
);

    localparam int          PAD        = ALIGN - 1 + HDR_BYTES;
    localparam int          CW         = $clog2(MARKER_DEPTH + 1);
    localparam int          AW         = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
    localparam logic [33:0] ALIGN_MASK = ~34'(ALIGN - 1);
    localparam logic [33:0] PAD_W      = 34'(PAD);

    logic [31:0]   base_reg;
    logic [31:0]   cap_reg;
    logic [31:0]   top_reg;
    logic [31:0]   top_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    mode_t         op_mode_reg;
    logic [31:0]   op_arg_reg;
    logic [32:0]   op_hdr_reg;
    logic          ok_reg;
    logic          ok_next;
    logic [31:0]   address_reg;
    logic [31:0]   address_next;
    logic [31:0]   haddr_reg;
    logic [31:0]   haddr_next;
    logic [32:0]   hval_reg;
    logic [32:0]   hval_next;

    logic [33:0]   new_top;
    logic [33:0]   aligned_alloc;
    logic [32:0]   limit;
    logic          fits;
    logic          hdr_ok;
    logic [32:0]   freed_top;
    logic [33:0]   cand;
    logic          not_full;
    logic          not_empty;
    logic [CW-1:0] count_dec;
    logic          ram_we;
    logic [31:0]   ram_rdata;

    assign new_top       = {2'b00, top_reg} + PAD_W + {2'b00, op_arg_reg};
    assign aligned_alloc = ({2'b00, top_reg} + PAD_W) & ALIGN_MASK;
    assign limit         = {1'b0, base_reg} + {1'b0, cap_reg};
    assign fits          = (new_top <= {1'b0, limit}) && (new_top[33:32] == 2'b00);

    assign hdr_ok    = op_hdr_reg <= {1'b0, top_reg};
    assign freed_top = {1'b0, top_reg} - op_hdr_reg;
    assign cand      = ({1'b0, freed_top} + PAD_W) & ALIGN_MASK;

    assign not_full  = count_reg < CW'(MARKER_DEPTH);
    assign not_empty = count_reg != '0;
    assign count_dec = count_reg - CW'(1);

    // read address follows the count while idle; data is ready in the execute beat
    asa_ram #(
        .WIDTH (32),
        .DEPTH (MARKER_DEPTH)
    ) u_markers (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (top_reg),
        .raddr (count_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        top_next     = top_reg;
        count_next   = count_reg;
        ok_next      = 1'b0;
        address_next = '0;
        haddr_next   = '0;
        hval_next    = '0;
        ram_we       = 1'b0;
        case (op_mode_reg)
            MODE_ALLOC:
            begin
                if (fits)
                begin
                    ok_next      = 1'b1;
                    top_next     = new_top[31:0];
                    address_next = aligned_alloc[31:0];
                    haddr_next   = aligned_alloc[31:0] - 32'(HDR_BYTES);
                    hval_next    = {1'b0, op_arg_reg} + PAD_W[32:0];
                end
            end
            MODE_FREE:
            begin
                if (hdr_ok && (cand == {2'b00, op_arg_reg}))
                begin
                    ok_next  = 1'b1;
                    top_next = freed_top[31:0];
                end
            end
            MODE_PUSH:
            begin
                if (not_full)
                begin
                    ok_next    = 1'b1;
                    ram_we     = cmd.exec;
                    count_next = count_reg + CW'(1);
                end
            end
            MODE_POP:
            begin
                if (not_empty)
                begin
                    ok_next    = 1'b1;
                    count_next = count_dec;
                    top_next   = ram_rdata;
                end
            end
            default: ok_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            cap_reg   <= '0;
            top_reg   <= '0;
            count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_BASE:
                begin
                    base_reg <= cfg_data;
                    top_reg  <= cfg_data;
                end
                REG_CAPACITY:
                begin
                    cap_reg <= cfg_data;
                    top_reg <= base_reg;
                end
                default: top_reg <= base_reg;
            endcase
        end
        else if (cmd.exec)
        begin
            top_reg   <= top_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_mode_reg <= mode_t'(mode);
            op_arg_reg  <= amount_or_pointer;
            op_hdr_reg  <= stored_header;
        end
        if (cmd.exec)
        begin
            ok_reg      <= ok_next;
            address_reg <= address_next;
            haddr_reg   <= haddr_next;
            hval_reg    <= hval_next;
        end
    end

    assign ok             = ok_reg;
    assign address        = address_reg;
    assign header_address = haddr_reg;
    assign header_value   = hval_reg;

endmodule

// File: sv/aligned_stack_allocator.sv
// Aligned stack allocator: each operation is accepted on start while busy is
// low, evaluated in the following cycle and its result shown for one cycle on
// done, alike in all modes; no new operation is taken while busy. The execute
// state is set by the registered read of the marker RAM that a pop needs; the
// same state serves the wide add and compare of an allocate. Results stay on
// the outputs until the next operation; done is a single-cycle beat and the
// receiver cannot stall. Depends on asa_pkg, asa_ctrl, asa_dp and asa_ram.
module aligned_stack_allocator
    import asa_pkg::*;
#(
    parameter int ALIGN        = 16,
    parameter int MARKER_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [1:0]  mode,
    input  logic [31:0] amount_or_pointer,
    input  logic [32:0] stored_header,
    output logic        ok,
    output logic [31:0] address,
    output logic [31:0] header_address,
    output logic [32:0] header_value
);

    cmd_t cmd;

    asa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    asa_dp #(
        .ALIGN        (ALIGN),
        .MARKER_DEPTH (MARKER_DEPTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mode              (mode),
        .amount_or_pointer (amount_or_pointer),
        .stored_header     (stored_header),
        .ok                (ok),
        .address           (address),
        .header_address    (header_address),
        .header_value      (header_value)
    );

endmodule

// File: sv/asa_checker.sv
// Port-level checks for the aligned stack allocator, bound to the top level.
// Depends on aligned_stack_allocator.
module asa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        ok,
    input logic [31:0] address,
    input logic [31:0] header_address,
    input logic [32:0] header_value
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("result beat missing two cycles after accept");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ok |-> address == '0 && header_address == '0 && header_value == '0)
        else $error("failed operation carries non-zero payload");

    a_header_below: assert property (@(posedge clk) disable iff (!rst_n)
        done && address != '0 |-> header_address == address - 32'd8)
        else $error("header address not eight below block address");

endmodule

bind aligned_stack_allocator asa_checker u_asa_checker (.*);
